// ===== rtl/kvs_pkg.sv =====
// Package for the packed record key-value store.
// Holds the sizes, widths, codes and shared types used by the RAM and the top level.
// Depends on nothing.
package kvs_pkg;

    localparam int STORE_BYTES = 1024;
    localparam int MAX_VALUE   = 32;
    localparam int HDR         = 3;
    localparam int MAX_READ    = 64;

    localparam int AW  = $clog2(STORE_BYTES);
    localparam int PW  = ((AW > 8) ? AW : 8) + 1;
    localparam int CW  = $clog2(MAX_VALUE + 1);
    localparam int SIW = (MAX_VALUE > 1) ? $clog2(MAX_VALUE) : 1;
    localparam int RCW = $clog2(MAX_READ + 1);

    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_CLEAR  = 3'd3,
        MODE_SIZE   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_SPACE  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_F_ADDR,
        S_F_LEN,
        S_F_KLO,
        S_F_KHI,
        S_R_ADDR,
        S_R_DATA,
        S_C_RD,
        S_C_WR,
        S_A_ADDR,
        S_A_LEN,
        S_A_CHECK,
        S_W_BYTE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [7:0]    wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } ram_req_t;

endpackage

// ===== rtl/kvs_ram.sv =====
// Byte store memory of the packed record key-value store.
// One write port and one registered read port; uses kvs_pkg for size and request type.
// Depends on kvs_pkg.
module kvs_ram (
    input  logic              clk,
    input  kvs_pkg::ram_req_t req,
    output logic [7:0]        rdata
);

    logic [7:0] mem [kvs_pkg::STORE_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// ===== rtl/packed_record_key_value_store.sv =====
// Each item is taken only when the block is idle and then runs on one shared byte memory
// under a sequencer. A lookup walks the records, reading the length and both key bytes of
// each; a compaction moves each byte after the found record down to the end of the store; the
// search for the end of the list before an append walks the records by their lengths; and the
// append writes the length, the key bytes, the value bytes and a closing zero byte. A value
// byte that is not the last, or an unused mode, leaves the block idle, and a read that finds
// its key gives one result item per value byte, waiting while the result side stalls. No
// clearing pass is run after reset: offset 0 reads as zero until it is first written.
// Top level; depends on kvs_pkg and kvs_ram.
module packed_record_key_value_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // key [15:0], data_byte [23:16]
    input  logic [2:0]  s_axis_tuser,  // mode [2:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // read_byte [7:0], value_length [14:8], zero [15]
    output logic [1:0]  m_axis_tuser,  // status [1:0]
    output logic        m_axis_tlast
);

    localparam int PW = kvs_pkg::PW;

    kvs_pkg::state_t  state_reg, state_next;
    kvs_pkg::mode_t   op_reg, op_next;
    logic [15:0]      key_reg, key_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       klo_reg, klo_next;
    logic [PW-1:0]    idx_reg, idx_next;
    logic [15:0]      skey_reg, skey_next;
    logic [kvs_pkg::CW-1:0] scnt_reg, scnt_next;
    logic [7:0]       stage_mem [kvs_pkg::MAX_VALUE];
    logic             stage_we;
    logic             empty_reg, empty_next;
    logic             zmask_reg;
    kvs_pkg::status_t res_st_reg, res_st_next;
    logic [6:0]       res_vl_reg, res_vl_next;
    logic             ovalid_reg, ovalid_next;
    logic [1:0]       ost_reg, ost_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic [6:0]       ovl_reg, ovl_next;
    logic             olast_reg, olast_next;

    kvs_pkg::ram_req_t ram_req;
    logic [7:0]        ram_rdata;
    logic [7:0]        rbyte;
    logic [PW-1:0]     rd_addr;
    logic [PW-1:0]     wr_addr;
    logic [PW-1:0]     copy_end;
    logic [PW-1:0]     nread;
    logic              accept;

    kvs_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    assign rbyte         = zmask_reg ? 8'd0 : ram_rdata;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == kvs_pkg::S_IDLE);
    assign copy_end      = PW'(kvs_pkg::STORE_BYTES) - PW'(len_reg) - PW'(kvs_pkg::HDR);
    assign nread         = (len_reg > 8'(kvs_pkg::MAX_READ)) ? PW'(kvs_pkg::MAX_READ)
                                                             : PW'(len_reg);

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {1'b0, ovl_reg, obyte_reg};
    assign m_axis_tuser  = ost_reg;
    assign m_axis_tlast  = olast_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        klo_next    = klo_reg;
        idx_next    = idx_reg;
        skey_next   = skey_reg;
        scnt_next   = scnt_reg;
        stage_we    = 1'b0;
        empty_next  = empty_reg;
        res_st_next = res_st_reg;
        res_vl_next = res_vl_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        ost_next    = ost_reg;
        obyte_next  = obyte_reg;
        ovl_next    = ovl_reg;
        olast_next  = olast_reg;
        rd_addr     = pos_reg;
        wr_addr     = idx_reg;
        ram_req     = '0;

        case (state_reg)
            kvs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = kvs_pkg::mode_t'(s_axis_tuser);
                    key_next = s_axis_tdata[15:0];
                    pos_next = '0;
                    case (s_axis_tuser)
                        kvs_pkg::MODE_READ, kvs_pkg::MODE_DELETE, kvs_pkg::MODE_SIZE:
                        begin
                            state_next = kvs_pkg::S_F_ADDR;
                        end
                        kvs_pkg::MODE_WRITE:
                        begin
                            if (scnt_reg == '0)
                            begin
                                skey_next = s_axis_tdata[15:0];
                                key_next  = s_axis_tdata[15:0];
                            end
                            else
                            begin
                                key_next = skey_reg;
                            end
                            if (scnt_reg < kvs_pkg::CW'(kvs_pkg::MAX_VALUE))
                            begin
                                stage_we  = 1'b1;
                                scnt_next = scnt_reg + 1'b1;
                            end
                            if (s_axis_tlast)
                            begin
                                state_next = kvs_pkg::S_F_ADDR;
                            end
                        end
                        kvs_pkg::MODE_CLEAR:
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = '0;
                            ram_req.wdata = 8'd0;
                            empty_next    = 1'b0;
                            res_st_next   = kvs_pkg::ST_OK;
                            res_vl_next   = '0;
                            state_next    = kvs_pkg::S_EMIT;
                        end
                        default:
                        begin
                            state_next = kvs_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            kvs_pkg::S_F_ADDR:
            begin
                if (pos_reg + PW'(2) >= PW'(kvs_pkg::STORE_BYTES))
                begin
                    if (op_reg == kvs_pkg::MODE_WRITE)
                    begin
                        pos_next   = '0;
                        state_next = kvs_pkg::S_A_ADDR;
                    end
                    else
                    begin
                        res_st_next = kvs_pkg::ST_NOT_FOUND;
                        res_vl_next = '0;
                        state_next  = kvs_pkg::S_EMIT;
                    end
                end
                else
                begin
                    ram_req.re = 1'b1;
                    rd_addr    = pos_reg;
                    state_next = kvs_pkg::S_F_LEN;
                end
            end

            kvs_pkg::S_F_LEN:
            begin
                len_next = rbyte;
                if (rbyte == 8'd0)
                begin
                    if (op_reg == kvs_pkg::MODE_WRITE)
                    begin
                        pos_next   = '0;
                        state_next = kvs_pkg::S_A_ADDR;
                    end
                    else
                    begin
                        res_st_next = kvs_pkg::ST_NOT_FOUND;
                        res_vl_next = '0;
                        state_next  = kvs_pkg::S_EMIT;
                    end
                end
                else
                begin
                    ram_req.re = 1'b1;
                    rd_addr    = pos_reg + PW'(1);
                    state_next = kvs_pkg::S_F_KLO;
                end
            end

            kvs_pkg::S_F_KLO:
            begin
                klo_next   = rbyte;
                ram_req.re = 1'b1;
                rd_addr    = pos_reg + PW'(2);
                state_next = kvs_pkg::S_F_KHI;
            end

            kvs_pkg::S_F_KHI:
            begin
                if ({rbyte, klo_reg} == key_reg)
                begin
                    idx_next = pos_reg;
                    case (op_reg)
                        kvs_pkg::MODE_READ:
                        begin
                            idx_next   = '0;
                            state_next = kvs_pkg::S_R_ADDR;
                        end
                        kvs_pkg::MODE_SIZE:
                        begin
                            res_st_next = kvs_pkg::ST_OK;
                            res_vl_next = len_reg[6:0];
                            state_next  = kvs_pkg::S_EMIT;
                        end
                        default:
                        begin
                            state_next = kvs_pkg::S_C_RD;
                        end
                    endcase
                end
                else
                begin
                    pos_next   = pos_reg + PW'(len_reg) + PW'(kvs_pkg::HDR);
                    state_next = kvs_pkg::S_F_ADDR;
                end
            end

            kvs_pkg::S_R_ADDR:
            begin
                ram_req.re = 1'b1;
                rd_addr    = pos_reg + PW'(kvs_pkg::HDR) + idx_reg;
                state_next = kvs_pkg::S_R_DATA;
            end

            kvs_pkg::S_R_DATA:
            begin
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    ost_next    = kvs_pkg::ST_OK;
                    obyte_next  = rbyte;
                    ovl_next    = len_reg[6:0];
                    olast_next  = (idx_reg + PW'(1) == nread);
                    idx_next    = idx_reg + PW'(1);
                    state_next  = (idx_reg + PW'(1) == nread) ? kvs_pkg::S_IDLE
                                                              : kvs_pkg::S_R_ADDR;
                end
            end

            kvs_pkg::S_C_RD:
            begin
                if (idx_reg >= copy_end)
                begin
                    if (op_reg == kvs_pkg::MODE_WRITE)
                    begin
                        pos_next   = '0;
                        state_next = kvs_pkg::S_A_ADDR;
                    end
                    else
                    begin
                        res_st_next = kvs_pkg::ST_OK;
                        res_vl_next = '0;
                        state_next  = kvs_pkg::S_EMIT;
                    end
                end
                else
                begin
                    ram_req.re = 1'b1;
                    rd_addr    = idx_reg + PW'(len_reg) + PW'(kvs_pkg::HDR);
                    state_next = kvs_pkg::S_C_WR;
                end
            end

            kvs_pkg::S_C_WR:
            begin
                ram_req.we    = 1'b1;
                wr_addr       = idx_reg;
                ram_req.wdata = rbyte;
                if (idx_reg == '0)
                begin
                    empty_next = 1'b0;
                end
                idx_next   = idx_reg + PW'(1);
                state_next = kvs_pkg::S_C_RD;
            end

            kvs_pkg::S_A_ADDR:
            begin
                if (pos_reg >= PW'(kvs_pkg::STORE_BYTES))
                begin
                    state_next = kvs_pkg::S_A_CHECK;
                end
                else
                begin
                    ram_req.re = 1'b1;
                    rd_addr    = pos_reg;
                    state_next = kvs_pkg::S_A_LEN;
                end
            end

            kvs_pkg::S_A_LEN:
            begin
                if (rbyte == 8'd0)
                begin
                    state_next = kvs_pkg::S_A_CHECK;
                end
                else
                begin
                    pos_next   = pos_reg + PW'(rbyte) + PW'(kvs_pkg::HDR);
                    state_next = kvs_pkg::S_A_ADDR;
                end
            end

            kvs_pkg::S_A_CHECK:
            begin
                idx_next = '0;
                if (pos_reg + PW'(scnt_reg) + PW'(kvs_pkg::HDR) >= PW'(kvs_pkg::STORE_BYTES))
                begin
                    res_st_next = kvs_pkg::ST_NO_SPACE;
                    res_vl_next = '0;
                    scnt_next   = '0;
                    state_next  = kvs_pkg::S_EMIT;
                end
                else
                begin
                    state_next = kvs_pkg::S_W_BYTE;
                end
            end

            kvs_pkg::S_W_BYTE:
            begin
                ram_req.we = 1'b1;
                wr_addr    = pos_reg + idx_reg;
                if (pos_reg + idx_reg == '0)
                begin
                    empty_next = 1'b0;
                end
                if (idx_reg == '0)
                begin
                    ram_req.wdata = 8'(scnt_reg);
                end
                else if (idx_reg == PW'(1))
                begin
                    ram_req.wdata = skey_reg[7:0];
                end
                else if (idx_reg == PW'(2))
                begin
                    ram_req.wdata = skey_reg[15:8];
                end
                else if (idx_reg == PW'(scnt_reg) + PW'(kvs_pkg::HDR))
                begin
                    ram_req.wdata = 8'd0;
                end
                else
                begin
                    ram_req.wdata = stage_mem[kvs_pkg::SIW'(idx_reg - PW'(kvs_pkg::HDR))];
                end
                idx_next = idx_reg + PW'(1);
                if (idx_reg == PW'(scnt_reg) + PW'(kvs_pkg::HDR))
                begin
                    res_st_next = kvs_pkg::ST_OK;
                    res_vl_next = 7'(scnt_reg);
                    scnt_next   = '0;
                    state_next  = kvs_pkg::S_EMIT;
                end
            end

            kvs_pkg::S_EMIT:
            begin
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    ost_next    = res_st_reg;
                    obyte_next  = 8'd0;
                    ovl_next    = res_vl_reg;
                    olast_next  = 1'b1;
                    state_next  = kvs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = kvs_pkg::S_IDLE;
            end
        endcase

        ram_req.raddr = rd_addr[kvs_pkg::AW-1:0];
        if (state_reg != kvs_pkg::S_IDLE)
        begin
            ram_req.waddr = wr_addr[kvs_pkg::AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= kvs_pkg::S_IDLE;
            scnt_reg   <= '0;
            skey_reg   <= '0;
            empty_reg  <= 1'b1;
            zmask_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            scnt_reg   <= scnt_next;
            skey_reg   <= skey_next;
            empty_reg  <= empty_next;
            zmask_reg  <= ram_req.re && (ram_req.raddr == '0) && empty_reg;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        len_reg    <= len_next;
        klo_reg    <= klo_next;
        idx_reg    <= idx_next;
        res_st_reg <= res_st_next;
        res_vl_reg <= res_vl_next;
        ost_reg    <= ost_next;
        obyte_reg  <= obyte_next;
        ovl_reg    <= ovl_next;
        olast_reg  <= olast_next;
        if (stage_we)
        begin
            stage_mem[kvs_pkg::SIW'(scnt_reg)] <= s_axis_tdata[23:16];
        end
    end

    a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scnt_reg <= kvs_pkg::CW'(kvs_pkg::MAX_VALUE))
        else $error("staging count exceeds the value limit");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we && state_reg != kvs_pkg::S_IDLE |-> wr_addr < PW'(kvs_pkg::STORE_BYTES))
        else $error("store write outside the store");

    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && ost_reg == kvs_pkg::ST_NOT_FOUND |-> obyte_reg == 8'd0
            && ovl_reg == 7'd0 && olast_reg)
        else $error("not-found result carries data");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !m_axis_tready |=> ovalid_reg)
        else $error("result dropped before it was taken");

endmodule
